// ===== rtl/core/decimal_text_to_double_defines.svh =====
// Assertion helpers for the converter's top-level RTL file.
// Each macro expects clk and arst_n in scope.
`ifndef DECIMAL_TEXT_TO_DOUBLE_DEFINES_SVH
`define DECIMAL_TEXT_TO_DOUBLE_DEFINES_SVH
// Consequent must hold in the same cycle as the antecedent.
`define DTTD_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define DTTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/dttd_pkg.sv =====
`default_nettype none
package dttd_pkg;

	localparam int EXP_LIMIT = 400;
	localparam int EXP_W = $clog2(EXP_LIMIT + 1);
	// first exponent counts that fall outside the double range
	localparam int POS_MAX = 309;
	localparam int NEG_MAX = 324;

	localparam logic [63:0] FP_ZERO  = 64'h0000_0000_0000_0000;
	localparam logic [63:0] FP_ONE   = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] FP_TEN   = 64'h4024_0000_0000_0000;
	localparam logic [63:0] FP_TENTH = 64'h3FB9_9999_9999_999A;
	localparam logic [63:0] FP_INF   = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] FP_NAN   = 64'hFFF8_0000_0000_0000;

	localparam int EW = 14;
	typedef logic signed [EW-1:0] fexp_t;

	typedef enum logic {
		FOP_MUL = 1'b0,
		FOP_ADD = 1'b1
	} fop_t;

	typedef struct packed {
		logic        start;
		fop_t        op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} fp_rsp_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [EXP_W-1:0] k;
	} pow_req_t;

	function automatic logic [63:0] digit_double(input logic [3:0] d);
		logic [63:0] v;
		unique case (d)
			4'd0: v = FP_ZERO;
			4'd1: v = FP_ONE;
			4'd2: v = 64'h4000_0000_0000_0000;
			4'd3: v = 64'h4008_0000_0000_0000;
			4'd4: v = 64'h4010_0000_0000_0000;
			4'd5: v = 64'h4014_0000_0000_0000;
			4'd6: v = 64'h4018_0000_0000_0000;
			4'd7: v = 64'h401C_0000_0000_0000;
			4'd8: v = 64'h4020_0000_0000_0000;
			4'd9: v = 64'h4022_0000_0000_0000;
			default: v = FP_ZERO;
		endcase
		return v;
	endfunction

	// Round a positive value m * 2^(e-127), m[127] set, to nearest even.
	function automatic logic [63:0] fp_round(input logic [127:0] m, input fexp_t e);
		fexp_t       biased;
		fexp_t       shn;
		logic [7:0]  sh;
		logic [255:0] ext;
		logic [51:0] r;
		logic        guard;
		logic        sticky;
		logic [63:0] bits;
		biased = e + fexp_t'(1023);
		shn = fexp_t'(-947) - e;
		if (biased >= fexp_t'(1))
			sh = 8'd75;
		else if (shn > fexp_t'(255))
			sh = 8'd255;
		else
			sh = shn[7:0];
		ext = {m, 128'b0} >> sh;
		r = ext[179:128];
		guard = ext[127];
		sticky = |ext[126:0];
		if (biased >= fexp_t'(1))
			bits = {1'b0, biased[10:0], r};
		else
			bits = {12'b0, r};
		if (guard && (sticky || r[0]))
			bits = bits + 64'd1;
		if (biased >= fexp_t'(2047))
			bits = FP_INF;
		return bits;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dttd_fpu.sv =====
`default_nettype none
module dttd_fpu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dttd_pkg::fpu_req_t req,
	output dttd_pkg::fp_rsp_t      rsp
);
	import dttd_pkg::*;

	typedef enum logic [5:0] {
		FS_IDLE  = 6'b000001,
		FS_NORM  = 6'b000010,
		FS_PROD  = 6'b000100,
		FS_PACK  = 6'b001000,
		FS_ALIGN = 6'b010000,
		FS_ROUND = 6'b100000
	} fs_t;

	function automatic fexp_t unb(input logic [10:0] f);
		fexp_t v;
		if (f == 11'd0)
			v = fexp_t'(-1022);
		else
			v = $signed({3'b0, f}) - fexp_t'(1023);
		return v;
	endfunction

	fs_t          st_q;
	logic [52:0]  sa_q, sb_q;
	fexp_t        ea_q, eb_q;
	logic [105:0] prod_q;
	logic [1:0]   pcnt_q;
	logic [127:0] m_q;
	fexp_t        e_q;
	logic [63:0]  res_q;
	logic         done_q;

	logic [10:0] fa, fb;
	logic        a_zero, b_zero, a_inf, b_inf;
	assign fa = req.a[62:52];
	assign fb = req.b[62:52];
	assign a_zero = (req.a[62:0] == 63'd0);
	assign b_zero = (req.b[62:0] == 63'd0);
	assign a_inf = (fa == 11'h7FF);
	assign b_inf = (fb == 11'h7FF);

	// partial product of the 53 x 53 significand multiply
	logic [26:0] op1, op2;
	logic [53:0] pp;
	logic [6:0]  pp_sh;
	assign op1 = pcnt_q[1] ? sa_q[52:26] : {1'b0, sa_q[25:0]};
	assign op2 = pcnt_q[0] ? sb_q[52:26] : {1'b0, sb_q[25:0]};
	assign pp = op1 * op2;
	assign pp_sh = 7'd26 * (7'(pcnt_q[1]) + 7'(pcnt_q[0]));

	// alignment and add of two positive operands
	fexp_t        dexp;
	logic         dlarge;
	logic [180:0] wsh;
	logic [127:0] mb;
	logic         stk;
	logic [128:0] sum;
	logic [127:0] add_m;
	fexp_t        add_e;
	always_comb begin
		dexp = ea_q - eb_q;
		dlarge = (dexp > fexp_t'(180));
		wsh = {sb_q, 128'b0} >> dexp[7:0];
		mb = dlarge ? 128'd0 : wsh[180:53];
		stk = dlarge ? 1'b1 : |wsh[52:0];
		sum = {1'b0, sa_q, 75'b0} + {1'b0, mb};
		if (sum[128]) begin
			add_m = {sum[128:2], sum[1] | sum[0] | stk};
			add_e = ea_q + fexp_t'(1);
		end else begin
			add_m = {sum[127:1], sum[0] | stk};
			add_e = ea_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FS_IDLE;
			done_q <= 1'b0;
			pcnt_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				FS_IDLE: begin
					if (req.start) begin
						if (req.op == FOP_MUL) begin
							if (a_inf || b_inf) begin
								res_q <= (a_zero || b_zero) ? FP_NAN : FP_INF;
								done_q <= 1'b1;
							end else if (a_zero || b_zero) begin
								res_q <= FP_ZERO;
								done_q <= 1'b1;
							end else begin
								sa_q <= {fa != 11'd0, req.a[51:0]};
								sb_q <= {fb != 11'd0, req.b[51:0]};
								ea_q <= unb(fa);
								eb_q <= unb(fb);
								prod_q <= '0;
								pcnt_q <= 2'd0;
								st_q <= FS_NORM;
							end
						end else begin
							if (a_inf || b_inf) begin
								res_q <= FP_INF;
								done_q <= 1'b1;
							end else if (fa == 11'd0 && fb == 11'd0) begin
								// subnormal sums are exact on the raw encodings
								res_q <= req.a + req.b;
								done_q <= 1'b1;
							end else if (fa >= fb) begin
								sa_q <= {1'b1, req.a[51:0]};
								sb_q <= {fb != 11'd0, req.b[51:0]};
								ea_q <= unb(fa);
								eb_q <= unb(fb);
								st_q <= FS_ALIGN;
							end else begin
								sa_q <= {1'b1, req.b[51:0]};
								sb_q <= {fa != 11'd0, req.a[51:0]};
								ea_q <= unb(fb);
								eb_q <= unb(fa);
								st_q <= FS_ALIGN;
							end
						end
					end
				end
				FS_NORM: begin
					// one bit a cycle until both significands carry a leading one
					if (!sa_q[52]) begin
						sa_q <= {sa_q[51:0], 1'b0};
						ea_q <= ea_q - fexp_t'(1);
					end else if (!sb_q[52]) begin
						sb_q <= {sb_q[51:0], 1'b0};
						eb_q <= eb_q - fexp_t'(1);
					end else begin
						st_q <= FS_PROD;
					end
				end
				FS_PROD: begin
					prod_q <= prod_q + ({52'b0, pp} << pp_sh);
					pcnt_q <= pcnt_q + 2'd1;
					if (pcnt_q == 2'd3)
						st_q <= FS_PACK;
				end
				FS_PACK: begin
					if (prod_q[105]) begin
						m_q <= {prod_q, 22'b0};
						e_q <= ea_q + eb_q + fexp_t'(1);
					end else begin
						m_q <= {prod_q[104:0], 23'b0};
						e_q <= ea_q + eb_q;
					end
					st_q <= FS_ROUND;
				end
				FS_ALIGN: begin
					m_q <= add_m;
					e_q <= add_e;
					st_q <= FS_ROUND;
				end
				FS_ROUND: begin
					res_q <= fp_round(m_q, e_q);
					done_q <= 1'b1;
					st_q <= FS_IDLE;
				end
				default: st_q <= FS_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/dttd_pow10.sv =====
`default_nettype none
module dttd_pow10 (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dttd_pkg::pow_req_t req,
	output dttd_pkg::fp_rsp_t      rsp
);
	import dttd_pkg::*;

	typedef enum logic [4:0] {
		PS_IDLE  = 5'b00001,
		PS_STEP  = 5'b00010,
		PS_DIV   = 5'b00100,
		PS_DNORM = 5'b01000,
		PS_ROUND = 5'b10000
	} ps_t;

	ps_t              st_q;
	logic [127:0]     m_q;
	fexp_t            e_q;
	logic [EXP_W-1:0] cnt_q;
	logic             neg_q;
	logic [135:0]     dvd_q;
	logic [135:0]     q_q;
	logic [3:0]       rem_q;
	logic [4:0]       dcnt_q;
	logic [63:0]      res_q;
	logic             done_q;

	logic [131:0] times10;
	assign times10 = ({4'b0, m_q} << 3) + ({4'b0, m_q} << 1);

	// eight quotient bits of the divide by ten
	logic [7:0] qb;
	logic [3:0] rem_n;
	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r = rem_q;
		qb = 8'd0;
		for (int i = 0; i < 8; i++) begin
			t = {r, dvd_q[135 - i]};
			if (t >= 5'd10) begin
				t = t - 5'd10;
				qb[7 - i] = 1'b1;
			end
			r = t[3:0];
		end
		rem_n = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PS_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				PS_IDLE: begin
					if (req.start) begin
						if (req.neg && req.k >= EXP_W'(NEG_MAX)) begin
							res_q <= FP_ZERO;
							done_q <= 1'b1;
						end else if (!req.neg && req.k >= EXP_W'(POS_MAX)) begin
							res_q <= FP_INF;
							done_q <= 1'b1;
						end else begin
							m_q <= {1'b1, 127'b0};
							e_q <= '0;
							cnt_q <= req.k;
							neg_q <= req.neg;
							st_q <= PS_STEP;
						end
					end
				end
				PS_STEP: begin
					if (cnt_q == '0) begin
						st_q <= PS_ROUND;
					end else if (neg_q) begin
						dvd_q <= {m_q, 8'b0};
						q_q <= '0;
						rem_q <= 4'd0;
						dcnt_q <= 5'd0;
						st_q <= PS_DIV;
					end else begin
						if (times10[131]) begin
							m_q <= times10[131:4];
							e_q <= e_q + fexp_t'(4);
						end else begin
							m_q <= times10[130:3];
							e_q <= e_q + fexp_t'(3);
						end
						cnt_q <= cnt_q - 1'b1;
					end
				end
				PS_DIV: begin
					dvd_q <= {dvd_q[127:0], 8'b0};
					q_q <= {q_q[127:0], qb};
					rem_q <= rem_n;
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'd16)
						st_q <= PS_DNORM;
				end
				PS_DNORM: begin
					if (q_q[132]) begin
						m_q <= q_q[132:5];
						e_q <= e_q - fexp_t'(3);
					end else begin
						m_q <= q_q[131:4];
						e_q <= e_q - fexp_t'(4);
					end
					cnt_q <= cnt_q - 1'b1;
					st_q <= PS_STEP;
				end
				PS_ROUND: begin
					res_q <= fp_round(m_q, e_q);
					done_q <= 1'b1;
					st_q <= PS_IDLE;
				end
				default: st_q <= PS_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/decimal_text_to_double.sv =====
// Decimal text to IEEE double converter. Feed a numeric token one ASCII
// character per item on char_code, with last_char set on its final character;
// the parsed binary64 pattern comes out on value_bits once per token. Leading
// whitespace, a sign, integer and fraction digits and an E/e/D/d exponent are
// understood; the first character that does not fit ends parsing, and the
// rest of the token is only counted for its last_char mark. A non-digit or
// exponent digit is taken by the parser alone; an integer digit runs a
// multiply and an add, and a fraction digit a scale, a multiply and an add,
// all on the shared multiply/add unit (four 27x27 partial products per
// multiply, after a shift per leading zero of a subnormal operand). The last
// character adds the power of ten build: a multiply by ten per step for 10^k
// or a divide by ten of 8 bits a cycle per step for 10^-k, then one more
// multiply. The next item is taken only when the current one is finished; a
// result may still wait in the output register meanwhile.
`default_nettype none
`include "decimal_text_to_double_defines.svh"
module decimal_text_to_double (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	input  wire logic        char_valid,
	output logic             char_stall,
	output logic [63:0]      value_bits,
	output logic             value_valid,
	input  wire logic        value_stall
);
	import dttd_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UP_D  = 8'd68;
	localparam logic [7:0] CH_UP_E  = 8'd69;
	localparam logic [7:0] CH_LO_D  = 8'd100;
	localparam logic [7:0] CH_LO_E  = 8'd101;
	localparam int NW = EXP_W + 4;

	// parser phase
	typedef enum logic [5:0] {
		PH_WS    = 6'b000001,
		PH_INT   = 6'b000010,
		PH_FRAC  = 6'b000100,
		PH_ESIGN = 6'b001000,
		PH_EDIG  = 6'b010000,
		PH_DONE  = 6'b100000
	} phase_t;

	// sequencer: each arithmetic state runs one operation on the shared unit or, in ST_POW, on the power of ten unit
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_IMUL   = 9'b000000010,
		ST_IADD   = 9'b000000100,
		ST_FSCALE = 9'b000001000,
		ST_FPROD  = 9'b000010000,
		ST_FADD   = 9'b000100000,
		ST_POW    = 9'b001000000,
		ST_FINAL  = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} st_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_INT  = 2'd1,
		ACT_FRAC = 2'd2
	} act_t;

	st_t              st_q;
	phase_t           phase_q;
	logic             mneg_q;
	logic             eneg_q;
	logic [EXP_W-1:0] exp_cnt_q;
	logic [63:0]      acc_q;
	logic [63:0]      scale_q;
	logic [63:0]      tmp_q;
	logic [63:0]      pow_q;
	logic [3:0]       digit_q;
	logic             last_q;
	logic             wait_q;
	logic [63:0]      value_q;
	logic             value_valid_q;

	fpu_req_t fpu_req;
	fp_rsp_t  fpu_rsp;
	pow_req_t pow_req;
	fp_rsp_t  pow_rsp;

	logic accept;
	assign char_stall = (st_q != ST_IDLE);
	assign accept = char_valid && !char_stall;

	// character classes
	logic       is_dig, is_sp, is_em;
	logic [3:0] dig;
	assign is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_sp = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
	assign is_em = (char_code == CH_UP_E) || (char_code == CH_LO_E) ||
		(char_code == CH_UP_D) || (char_code == CH_LO_D);
	assign dig = char_code[3:0];

	// exponent digit, saturating at the limit
	logic [NW-1:0]    exp_n;
	logic [EXP_W-1:0] exp_sat;
	assign exp_n = ({4'b0, exp_cnt_q} * NW'(10)) + NW'(dig);
	assign exp_sat = (exp_n > NW'(EXP_LIMIT)) ? EXP_W'(EXP_LIMIT) : exp_n[EXP_W-1:0];

	// grammar step for the incoming character
	phase_t           ph_n;
	logic             mneg_n, eneg_n;
	logic [EXP_W-1:0] ecnt_n;
	act_t             act;
	always_comb begin
		logic take_num;
		take_num = 1'b0;
		ph_n = phase_q;
		mneg_n = mneg_q;
		eneg_n = eneg_q;
		ecnt_n = exp_cnt_q;
		act = ACT_NONE;
		unique case (phase_q)
			PH_WS: begin
				if (is_sp) begin
					ph_n = PH_WS;
				end else if (char_code == CH_MINUS) begin
					mneg_n = 1'b1;
					ph_n = PH_INT;
				end else if (char_code == CH_PLUS) begin
					ph_n = PH_INT;
				end else begin
					take_num = 1'b1;
				end
			end
			PH_INT: take_num = 1'b1;
			PH_FRAC: begin
				if (is_dig)
					act = ACT_FRAC;
				else if (is_em)
					ph_n = PH_ESIGN;
				else
					ph_n = PH_DONE;
			end
			PH_ESIGN: begin
				if (char_code == CH_MINUS) begin
					eneg_n = 1'b1;
					ph_n = PH_EDIG;
				end else if (char_code == CH_PLUS) begin
					ph_n = PH_EDIG;
				end else if (is_dig) begin
					ecnt_n = exp_sat;
					ph_n = PH_EDIG;
				end else begin
					ph_n = PH_DONE;
				end
			end
			PH_EDIG: begin
				if (is_dig)
					ecnt_n = exp_sat;
				else
					ph_n = PH_DONE;
			end
			default: ph_n = PH_DONE;
		endcase
		if (take_num) begin
			if (is_dig) begin
				act = ACT_INT;
				ph_n = PH_INT;
			end else if (char_code == CH_DOT) begin
				ph_n = PH_FRAC;
			end else if (is_em) begin
				ph_n = PH_ESIGN;
			end else begin
				ph_n = PH_DONE;
			end
		end
	end

	// operands for the shared unit, chosen by the sequencer state
	logic fpu_state;
	always_comb begin
		fpu_req.op = FOP_MUL;
		fpu_req.a = acc_q;
		fpu_req.b = FP_TEN;
		fpu_state = 1'b1;
		unique case (st_q)
			ST_IMUL: begin
				fpu_req.a = acc_q;
				fpu_req.b = FP_TEN;
			end
			ST_IADD: begin
				fpu_req.op = FOP_ADD;
				fpu_req.a = tmp_q;
				fpu_req.b = digit_double(digit_q);
			end
			ST_FSCALE: begin
				fpu_req.a = scale_q;
				fpu_req.b = FP_TENTH;
			end
			ST_FPROD: begin
				fpu_req.a = digit_double(digit_q);
				fpu_req.b = scale_q;
			end
			ST_FADD: begin
				fpu_req.op = FOP_ADD;
				fpu_req.a = acc_q;
				fpu_req.b = tmp_q;
			end
			ST_FINAL: begin
				fpu_req.a = acc_q;
				fpu_req.b = pow_q;
			end
			default: fpu_state = 1'b0;
		endcase
		fpu_req.start = fpu_state && !wait_q;
	end

	assign pow_req.start = (st_q == ST_POW) && !wait_q;
	assign pow_req.neg = eneg_q;
	assign pow_req.k = exp_cnt_q;

	dttd_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	dttd_pow10 u_pow10 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (pow_req),
		.rsp    (pow_rsp)
	);

	logic emit_go;
	assign emit_go = (st_q == ST_EMIT) && (!value_valid_q || !value_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= PH_WS;
			mneg_q <= 1'b0;
			eneg_q <= 1'b0;
			exp_cnt_q <= '0;
			acc_q <= FP_ZERO;
			scale_q <= FP_ONE;
			wait_q <= 1'b0;
			last_q <= 1'b0;
			value_valid_q <= 1'b0;
		end else begin
			// drop the result once taken
			if (value_valid_q && !value_stall)
				value_valid_q <= 1'b0;
			if (fpu_req.start || pow_req.start)
				wait_q <= 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= ph_n;
						mneg_q <= mneg_n;
						eneg_q <= eneg_n;
						exp_cnt_q <= ecnt_n;
						digit_q <= dig;
						last_q <= last_char;
						if (act == ACT_INT)
							st_q <= ST_IMUL;
						else if (act == ACT_FRAC)
							st_q <= ST_FSCALE;
						else if (last_char)
							st_q <= ST_POW;
					end
				end
				ST_IMUL: begin
					if (fpu_rsp.done) begin
						tmp_q <= fpu_rsp.res;
						wait_q <= 1'b0;
						st_q <= ST_IADD;
					end
				end
				ST_IADD: begin
					if (fpu_rsp.done) begin
						acc_q <= fpu_rsp.res;
						wait_q <= 1'b0;
						st_q <= last_q ? ST_POW : ST_IDLE;
					end
				end
				ST_FSCALE: begin
					if (fpu_rsp.done) begin
						scale_q <= fpu_rsp.res;
						wait_q <= 1'b0;
						st_q <= ST_FPROD;
					end
				end
				ST_FPROD: begin
					if (fpu_rsp.done) begin
						tmp_q <= fpu_rsp.res;
						wait_q <= 1'b0;
						st_q <= ST_FADD;
					end
				end
				ST_FADD: begin
					if (fpu_rsp.done) begin
						acc_q <= fpu_rsp.res;
						wait_q <= 1'b0;
						st_q <= last_q ? ST_POW : ST_IDLE;
					end
				end
				ST_POW: begin
					if (pow_rsp.done) begin
						pow_q <= pow_rsp.res;
						wait_q <= 1'b0;
						st_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (fpu_rsp.done) begin
						tmp_q <= fpu_rsp.res;
						wait_q <= 1'b0;
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free, then clear the token
					if (emit_go) begin
						value_q <= {tmp_q[63] ^ mneg_q, tmp_q[62:0]};
						value_valid_q <= 1'b1;
						phase_q <= PH_WS;
						mneg_q <= 1'b0;
						eneg_q <= 1'b0;
						exp_cnt_q <= '0;
						acc_q <= FP_ZERO;
						scale_q <= FP_ONE;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign value_bits = value_q;
	assign value_valid = value_valid_q;

	`DTTD_ASSERT_HOLDS(a_fpu_rsp_expected, fpu_rsp.done, wait_q && fpu_state, "unexpected unit result")
	`DTTD_ASSERT_HOLDS(a_pow_rsp_expected, pow_rsp.done, wait_q && st_q == ST_POW, "unexpected power")
	`DTTD_ASSERT_NEXT(a_emit_clears, emit_go, value_valid_q && st_q == ST_IDLE && acc_q == FP_ZERO, "emit did not clear")
	`DTTD_ASSERT_HOLDS(a_exp_sat, 1'b1, exp_cnt_q <= EXP_W'(EXP_LIMIT), "exponent count above limit")

endmodule
`default_nettype wire
